// ===== src/pslp_pkg.sv =====
package pslp_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned STR_LEN_W = 11;
	localparam int unsigned MAX_LEN_DEFAULT = 1024;

	localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CH_W-1:0] CH_BS     = 8'h08;
	localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
	localparam logic [CH_W-1:0] CH_LOW_N  = 8'h6E;
	localparam logic [CH_W-1:0] CH_LOW_R  = 8'h72;
	localparam logic [CH_W-1:0] CH_LOW_T  = 8'h74;
	localparam logic [CH_W-1:0] CH_LOW_B  = 8'h62;
	localparam logic [CH_W-1:0] CH_LOW_F  = 8'h66;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_SEVEN  = 8'h37;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_OCT2   = 2'd2,
		MODE_OCT3   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BYTE     = 2'd0,
		ST_CLOSED   = 2'd1,
		ST_EOF      = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic            has_result;
		logic            emit;
		logic            clear;
		logic            nest_inc;
		logic            nest_dec;
		mode_t           mode_next;
		logic [CH_W-1:0] oct_next;
		logic [CH_W-1:0] out_byte;
		status_t         status;
	} step_ctl_t;

endpackage

// ===== src/pslp_step.sv =====
module pslp_step
	import pslp_pkg::*;
(
	input  mode_t           mode,
	input  logic [CH_W-1:0] oct,
	input  logic [CH_W-1:0] ch,
	input  logic            eoi,
	input  logic            esc_en,
	input  logic            full,
	input  logic            nest_zero,
	output step_ctl_t       ctl
);

	logic [CH_W-1:0] oct_acc;
	logic            is_oct_digit;

	assign oct_acc      = {oct[CH_W-4:0], 3'b000} + ch - CH_ZERO;
	assign is_oct_digit = (ch >= CH_ZERO) && (ch <= CH_SEVEN);

	always_comb begin
		ctl            = '0;
		ctl.mode_next  = mode;
		ctl.oct_next   = oct;
		ctl.status     = ST_BYTE;
		unique case (mode)
			MODE_ESCAPE: begin
				ctl.mode_next = MODE_NORMAL;
				if (eoi) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_EOF;
				end else begin
					case (ch)
						CH_LF: ;
						CH_LOW_N: begin
							ctl.emit     = 1'b1;
							ctl.out_byte = CH_LF;
						end
						CH_LOW_R: begin
							ctl.emit     = 1'b1;
							ctl.out_byte = CH_CR;
						end
						CH_LOW_T: begin
							ctl.emit     = 1'b1;
							ctl.out_byte = CH_TAB;
						end
						CH_LOW_B: begin
							ctl.emit     = 1'b1;
							ctl.out_byte = CH_BS;
						end
						CH_LOW_F: begin
							ctl.emit     = 1'b1;
							ctl.out_byte = CH_FF;
						end
						default: begin
							if (is_oct_digit) begin
								ctl.oct_next  = ch - CH_ZERO;
								ctl.mode_next = MODE_OCT2;
							end else begin
								ctl.emit     = 1'b1;
								ctl.out_byte = ch;
							end
						end
					endcase
				end
			end
			MODE_OCT2: begin
				if (eoi) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_EOF;
				end else begin
					ctl.oct_next  = oct_acc;
					ctl.mode_next = MODE_OCT3;
				end
			end
			MODE_OCT3: begin
				if (eoi) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_EOF;
				end else begin
					ctl.oct_next  = oct_acc;
					ctl.mode_next = MODE_NORMAL;
					ctl.emit      = 1'b1;
					ctl.out_byte  = oct_acc;
				end
			end
			default: begin
				if (full) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_OVERFLOW;
				end else if (eoi) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_EOF;
				end else if (ch == CH_LPAREN) begin
					ctl.nest_inc = 1'b1;
					ctl.emit     = 1'b1;
					ctl.out_byte = ch;
				end else if (ch == CH_RPAREN && nest_zero) begin
					ctl.has_result = 1'b1;
					ctl.clear      = 1'b1;
					ctl.status     = ST_CLOSED;
				end else if (ch == CH_RPAREN) begin
					ctl.nest_dec = 1'b1;
					ctl.emit     = 1'b1;
					ctl.out_byte = ch;
				end else if (ch == CH_BSLASH && esc_en) begin
					ctl.mode_next = MODE_ESCAPE;
				end else begin
					ctl.emit     = 1'b1;
					ctl.out_byte = ch;
				end
			end
		endcase
		if (ctl.emit) begin
			ctl.has_result = 1'b1;
		end
	end

endmodule

// ===== src/paren_string_literal_parser.sv =====
// Channel   Dir  tdata                                 tuser
// s_axis    in   [7:0] ch                              [0] end_of_input
// m_axis    out  [7:0] out_byte, [18:8] string_length  [1:0] status
// cfg       in   cfg_wdata[0] escapes_enabled (written when cfg_we)
//
// One byte per cycle sustained, except while a stalled result holds the input register.
// The input register feeds one pass of step logic that updates the string
// state and loads the result register.
// arst_n clears the string state and sets escapes_enabled.
// A stalled result holds the input register only when that byte yields a result.
module paren_string_literal_parser
	import pslp_pkg::*;
#(
	parameter int unsigned MAX_LEN = MAX_LEN_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [18:8] string_length, zero pad
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

	logic                 esc_en_q;
	logic                 valid_s1;
	logic [CH_W-1:0]      ch_s1;
	logic                 eoi_s1;
	mode_t                mode_q;
	logic [CH_W-1:0]      oct_q;
	logic [CNT_W-1:0]     byte_count_q;
	logic [CNT_W-1:0]     nest_q;
	logic                 m_valid_s2;
	logic [CH_W-1:0]      out_byte_s2;
	status_t              status_s2;
	logic [STR_LEN_W-1:0] str_len_s2;
	step_ctl_t            ctl;
	logic                 out_free;
	logic                 adv_s1;
	logic                 load_s2;

	pslp_step u_step (
		.mode      (mode_q),
		.oct       (oct_q),
		.ch        (ch_s1),
		.eoi       (eoi_s1),
		.esc_en    (esc_en_q),
		.full      (byte_count_q >= MAX_CNT),
		.nest_zero (nest_q == '0),
		.ctl       (ctl)
	);

	assign out_free = !m_valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && (!ctl.has_result || out_free);
	assign load_s2  = adv_s1 && ctl.has_result;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_en_q <= 1'b1;
		end else if (cfg_we) begin
			esc_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eoi_s1 <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NORMAL;
			oct_q        <= '0;
			byte_count_q <= '0;
			nest_q       <= '0;
		end else if (adv_s1) begin
			if (ctl.clear) begin
				mode_q       <= MODE_NORMAL;
				oct_q        <= '0;
				byte_count_q <= '0;
				nest_q       <= '0;
			end else begin
				mode_q <= ctl.mode_next;
				oct_q  <= ctl.oct_next;
				if (ctl.emit) begin
					byte_count_q <= byte_count_q + 1'b1;
				end
				if (ctl.nest_inc) begin
					nest_q <= nest_q + 1'b1;
				end else if (ctl.nest_dec) begin
					nest_q <= nest_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_s2 <= 1'b0;
		end else if (load_s2) begin
			m_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			m_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			out_byte_s2 <= ctl.out_byte;
			status_s2   <= ctl.status;
			str_len_s2  <= (ctl.status == ST_CLOSED) ? STR_LEN_W'(byte_count_q) : '0;
		end
	end

	assign m_tvalid = m_valid_s2;
	assign m_tdata  = {5'b0, str_len_s2, out_byte_s2};
	assign m_tuser  = status_s2;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= MAX_CNT)
		else $error("byte count beyond buffer size");

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= byte_count_q)
		else $error("nesting level exceeds emitted bytes");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && ctl.status != ST_BYTE) |=>
		(byte_count_q == '0 && nest_q == '0 && mode_q == MODE_NORMAL))
		else $error("state not cleared after final status");

	a_final_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_s2 && status_s2 != ST_BYTE) |-> out_byte_s2 == '0)
		else $error("final status carries a byte");

	a_len_only_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_s2 && status_s2 != ST_CLOSED) |-> str_len_s2 == '0)
		else $error("length reported without close");
`endif

endmodule
